// ===== src/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGBA converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

	// degrees per hue sector
	localparam int SECTOR_DEG = 60;

	// chroma and value*100, units of 1/10000
	typedef logic [13:0] chroma_t;

	// channel amount scaled by 60, units of 1/600000 (max 600000)
	typedef logic [19:0] amount_t;

	// hue sector floor(h/60)
	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

endpackage

`default_nettype wire

// ===== src/hsv2rgb_front.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Stages 1-2: hue reduction, percent clamp, sector split and chroma product.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_front (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [9:0]           hue_deg,
	input  wire logic [6:0]           sat_pct,
	input  wire logic [6:0]           val_pct,
	output hsv2rgb_pkg::sector_t      sector_s2,
	output logic [5:0]                w_s2,
	output hsv2rgb_pkg::chroma_t      cc_s2,
	output hsv2rgb_pkg::chroma_t      vh_s2
);

	localparam int PCT_MAX  = 100;
	localparam int HUE_FULL = 360;
	localparam int SD       = hsv2rgb_pkg::SECTOR_DEG;

	logic [8:0] h_s1;
	logic [6:0] s_s1;
	logic [6:0] v_s1;

	logic [9:0] hue_red;
	logic [6:0] sat_cl;
	logic [6:0] val_cl;

	always_comb begin
		if (hue_deg >= 10'(2 * HUE_FULL)) begin
			hue_red = hue_deg - 10'(2 * HUE_FULL);
		end else if (hue_deg >= 10'(HUE_FULL)) begin
			hue_red = hue_deg - 10'(HUE_FULL);
		end else begin
			hue_red = hue_deg;
		end
		sat_cl = (sat_pct > 7'(PCT_MAX)) ? 7'(PCT_MAX) : sat_pct;
		val_cl = (val_pct > 7'(PCT_MAX)) ? 7'(PCT_MAX) : val_pct;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1 <= hue_red[8:0];
			s_s1 <= sat_cl;
			v_s1 <= val_cl;
		end
	end

	hsv2rgb_pkg::sector_t sec;
	logic [8:0]           base;
	logic [8:0]           frac9;
	logic [5:0]           frac;
	logic [5:0]           w;

	always_comb begin
		if (h_s1 >= 9'(5 * SD)) begin
			sec  = hsv2rgb_pkg::SEC_MR;
			base = 9'(5 * SD);
		end else if (h_s1 >= 9'(4 * SD)) begin
			sec  = hsv2rgb_pkg::SEC_BM;
			base = 9'(4 * SD);
		end else if (h_s1 >= 9'(3 * SD)) begin
			sec  = hsv2rgb_pkg::SEC_CB;
			base = 9'(3 * SD);
		end else if (h_s1 >= 9'(2 * SD)) begin
			sec  = hsv2rgb_pkg::SEC_GC;
			base = 9'(2 * SD);
		end else if (h_s1 >= 9'(SD)) begin
			sec  = hsv2rgb_pkg::SEC_YG;
			base = 9'(SD);
		end else begin
			sec  = hsv2rgb_pkg::SEC_RY;
			base = 9'd0;
		end
		frac9 = h_s1 - base;
		frac  = frac9[5:0];
		// x weight: rising in even sectors, falling in odd ones
		case (sec)
			hsv2rgb_pkg::SEC_YG,
			hsv2rgb_pkg::SEC_CB,
			hsv2rgb_pkg::SEC_MR: w = 6'(SD) - frac;
			default:             w = frac;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s2 <= sec;
			w_s2      <= w;
			cc_s2     <= {7'd0, v_s1} * {7'd0, s_s1};
			vh_s2     <= {7'd0, v_s1} * 14'(PCT_MAX);
		end
	end

endmodule

`default_nettype wire

// ===== src/hsv2rgb_mix.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Stages 3-4: scaled chroma, x and offset, then per-channel placement.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_mix (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire hsv2rgb_pkg::sector_t sector_s2,
	input  wire logic [5:0]           w_s2,
	input  wire hsv2rgb_pkg::chroma_t cc_s2,
	input  wire hsv2rgb_pkg::chroma_t vh_s2,
	output hsv2rgb_pkg::amount_t      r_s4,
	output hsv2rgb_pkg::amount_t      g_s4,
	output hsv2rgb_pkg::amount_t      b_s4
);

	localparam int SD = hsv2rgb_pkg::SECTOR_DEG;

	hsv2rgb_pkg::sector_t sector_s3;
	hsv2rgb_pkg::amount_t c60_s3;
	hsv2rgb_pkg::amount_t x60_s3;
	hsv2rgb_pkg::amount_t m60_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s3 <= sector_s2;
			c60_s3    <= {6'd0, cc_s2} * 20'(SD);
			x60_s3    <= {6'd0, cc_s2} * {14'd0, w_s2};
			m60_s3    <= ({6'd0, vh_s2} - {6'd0, cc_s2}) * 20'(SD);
		end
	end

	hsv2rgb_pkg::amount_t cm;
	hsv2rgb_pkg::amount_t xm;
	hsv2rgb_pkg::amount_t r;
	hsv2rgb_pkg::amount_t g;
	hsv2rgb_pkg::amount_t b;

	// sums never exceed 600000
	assign cm = c60_s3 + m60_s3;
	assign xm = x60_s3 + m60_s3;

	always_comb begin
		case (sector_s3)
			hsv2rgb_pkg::SEC_RY: begin r = cm;     g = xm;     b = m60_s3; end
			hsv2rgb_pkg::SEC_YG: begin r = xm;     g = cm;     b = m60_s3; end
			hsv2rgb_pkg::SEC_GC: begin r = m60_s3; g = cm;     b = xm;     end
			hsv2rgb_pkg::SEC_CB: begin r = m60_s3; g = xm;     b = cm;     end
			hsv2rgb_pkg::SEC_BM: begin r = xm;     g = m60_s3; b = cm;     end
			default:             begin r = cm;     g = m60_s3; b = xm;     end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4 <= r;
			g_s4 <= g;
			b_s4 <= b;
		end
	end

endmodule

`default_nettype wire

// ===== src/hsv2rgb_quant.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_quant
// Stages 5-8: byte = floor((255*a + 300000) / 600000) by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_quant (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire hsv2rgb_pkg::amount_t amount_s4,
	output logic [7:0]                chan_s8
);

	localparam int ROUND_BIAS = 300000;
	// 600000 = 64 * DIVISOR
	localparam int DIVISOR    = 9375;
	localparam longint RECIP  = (64'd1 << 32) / DIVISOR;

	logic [27:0] num;
	logic [21:0] t_s5;

	assign num = {8'd0, amount_s4} * 28'd255 + 28'(ROUND_BIAS);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5 <= num[27:6];
		end
	end

	logic [40:0] prod;
	logic [21:0] t_s6;
	logic [7:0]  q0_s6;

	// estimate is exact or one low
	assign prod = {19'd0, t_s5} * 41'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s6  <= t_s5;
			q0_s6 <= prod[39:32];
		end
	end

	logic [21:0] t_s7;
	logic [21:0] p_s7;
	logic [7:0]  q0_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s7  <= t_s6;
			q0_s7 <= q0_s6;
			p_s7  <= {14'd0, q0_s6} * 22'(DIVISOR);
		end
	end

	logic [21:0] rem;
	logic [8:0]  qn;

	assign rem = t_s7 - p_s7;
	assign qn  = {1'b0, q0_s7} + {8'd0, (rem >= 22'(DIVISOR))};

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s8 <= (qn > 9'd255) ? 8'hFF : qn[7:0];
		end
	end

endmodule

`default_nettype wire

// ===== src/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV (degrees, percent) to 8-bit RGBA stream converter, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction in and one out per clock while the output is not stalled.
// From input acceptance to the output register, two stages reduce hue and form chroma,
// two place the channel amounts, four quantize each channel through a
// reciprocal multiply and a one-step correction. The whole pipeline holds when
// the output register is full and not taken, so s_axis_tready follows
// m_axis_tready combinationally through one gate.
`default_nettype none

module hsv_to_rgb_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // hue_deg[9:0], sat_pct[16:10], val_pct[23:17]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
);

	localparam int DEPTH = 8;

	logic             en;
	logic [DEPTH-1:0] stage_vld_q;

	assign en            = !stage_vld_q[DEPTH-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = stage_vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	hsv2rgb_pkg::sector_t sector_s2;
	logic [5:0]           w_s2;
	hsv2rgb_pkg::chroma_t cc_s2;
	hsv2rgb_pkg::chroma_t vh_s2;

	hsv2rgb_front u_front (
		.clk       (clk),
		.en        (en),
		.hue_deg   (s_axis_tdata[9:0]),
		.sat_pct   (s_axis_tdata[16:10]),
		.val_pct   (s_axis_tdata[23:17]),
		.sector_s2 (sector_s2),
		.w_s2      (w_s2),
		.cc_s2     (cc_s2),
		.vh_s2     (vh_s2)
	);

	hsv2rgb_pkg::amount_t r_s4;
	hsv2rgb_pkg::amount_t g_s4;
	hsv2rgb_pkg::amount_t b_s4;

	hsv2rgb_mix u_mix (
		.clk       (clk),
		.en        (en),
		.sector_s2 (sector_s2),
		.w_s2      (w_s2),
		.cc_s2     (cc_s2),
		.vh_s2     (vh_s2),
		.r_s4      (r_s4),
		.g_s4      (g_s4),
		.b_s4      (b_s4)
	);

	logic [7:0] red_s8;
	logic [7:0] green_s8;
	logic [7:0] blue_s8;

	hsv2rgb_quant u_quant_r (
		.clk       (clk),
		.en        (en),
		.amount_s4 (r_s4),
		.chan_s8   (red_s8)
	);

	hsv2rgb_quant u_quant_g (
		.clk       (clk),
		.en        (en),
		.amount_s4 (g_s4),
		.chan_s8   (green_s8)
	);

	hsv2rgb_quant u_quant_b (
		.clk       (clk),
		.en        (en),
		.amount_s4 (b_s4),
		.chan_s8   (blue_s8)
	);

	assign m_axis_tdata = {8'hFF, blue_s8, green_s8, red_s8};

endmodule

`default_nettype wire

// ===== src/hsv2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks for the HSV to RGBA converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	// input side stalls only behind a held output transaction
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output back-pressure");

	// alpha byte is opaque on every output transaction
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'hFF))
		else $error("alpha byte not 255");

	// a stalled output transaction stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("output valid dropped under stall");

	// a stalled output transaction keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output data changed under stall");

	// an offered output transaction carries known data
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown(m_axis_tdata))
		else $error("output data unknown while valid");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

`default_nettype wire
